>>> hw/rtl/mcpid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcpid_pkg: shared types and constants for the multi-channel PID controller
// Item formats, status codes, controller phases and saturation helpers.
// ----------------------------------------------------------------------------
package mcpid_pkg;

   // number of channels in the state table
   localparam int CHANNELS = 64;
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // configuration register indexes
   localparam logic CSR_TIME_STEP     = 1'b0;
   localparam logic CSR_INV_TIME_STEP = 1'b1;

   localparam logic [16:0] TIME_STEP_RESET     = 17'd655;
   localparam logic [30:0] INV_TIME_STEP_RESET = 31'd6553600;

   // item function codes
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_STEP = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_UNDEF = 2'd1,
      STATUS_REDEF = 2'd2
   } status_type;

   typedef struct packed {
      logic               func;
      logic [5:0]         channel;
      logic signed [31:0] gain_p;
      logic signed [31:0] gain_i;
      logic signed [31:0] gain_d;
      logic signed [31:0] measured;
      logic signed [31:0] target;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] drive;
      logic [1:0]         status;
   } rsp_item_type;

   // one entry of the channel table
   typedef struct packed {
      logic signed [31:0] gain_p;
      logic signed [31:0] gain_i;
      logic signed [31:0] gain_d;
      logic signed [31:0] prev_err;
      logic signed [47:0] err_sum;
   } chan_rec_type;

   // controller states, also the datapath phase
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_EDT,
      PH_DIF,
      PH_KP,
      PH_KIH,
      PH_KIL,
      PH_KD,
      PH_FIN
   } phase_type;

   typedef struct packed {
      logic      accept;
      logic      finish;
      phase_type phase;
   } dp_cmd_type;

   typedef struct packed {
      logic compute;
   } dp_sts_type;

   // clamp a wide value to 32 bits signed
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [65:0] hi;
      logic signed [65:0] lo;
      hi = $signed(66'h0_7FFF_FFFF);
      lo = -$signed(66'h0_8000_0000);
      if (v > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // clamp a 50-bit value to 48 bits signed
   function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
      logic signed [49:0] hi;
      logic signed [49:0] lo;
      hi = $signed(50'h0_7FFF_FFFF_FFFF);
      lo = -$signed(50'h0_8000_0000_0000);
      if (v > hi) begin
         return 48'sh7FFF_FFFF_FFFF;
      end else if (v < lo) begin
         return 48'sh8000_0000_0000;
      end
      return v[47:0];
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/multi_channel_pid_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_pid_controller: table of discrete PID channels
// Loads channel gains and runs fixed-point Q16.16 control steps.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per handshake: a load (func 0) defines a channel's
//   gains and clears its error state; a step (func 1) takes measured and
//   target for a defined channel and answers with the drive value.
//   rsp_* returns exactly one item per request, with a status code.
//   csr_* writes time_step (index 0) and inverse_time_step (index 1); write
//   only while the block is idle.
// Phases:
//   A step item passes through the phases EDT, DIF, KP, KIH, KIL, KD and FIN
//   before its result reaches rsp_valid; a load or an error item goes from
//   acceptance straight to FIN. The next item is taken once the previous one
//   has reached the output register. Six products go through one shared
//   33x33 multiplier, one per cycle.
// Reset: all channels become undefined, and the configuration registers and
//   controller state take their reset values. The table itself is not cleared.
// Stall: while rsp_stall holds, the result stays put; one further item may
//   be accepted and worked up to its final phase, where it waits.
// ----------------------------------------------------------------------------
module multi_channel_pid_controller (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  mcpid_pkg::req_item_type req_item,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output mcpid_pkg::rsp_item_type rsp_item,
   input  wire                     csr_we,
   input  wire                     csr_index,
   input  wire [30:0]              csr_wdata
);

   mcpid_pkg::dp_cmd_type cmd;
   mcpid_pkg::dp_sts_type sts;

   mcpid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   mcpid_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_item  (req_item),
      .rsp_item  (rsp_item),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule
`default_nettype wire

>>> hw/rtl/mcpid_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcpid_ctrl: sequencer of the PID controller
// Runs the handshakes and steps the datapath through the multiply phases.
// ----------------------------------------------------------------------------
module mcpid_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output mcpid_pkg::dp_cmd_type cmd,
   input  mcpid_pkg::dp_sts_type sts
);

   mcpid_pkg::phase_type state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;
   logic                 accept;
   logic                 finish;

   // state and result flag registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mcpid_pkg::PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      accept       = 1'b0;
      finish       = 1'b0;
      state_in     = state_ff;
      case (state_ff)
         mcpid_pkg::PH_IDLE: begin
            accept = req_valid;
            if (req_valid) begin
               state_in = sts.compute ? mcpid_pkg::PH_EDT : mcpid_pkg::PH_FIN;
            end
         end
         mcpid_pkg::PH_EDT: state_in = mcpid_pkg::PH_DIF;
         mcpid_pkg::PH_DIF: state_in = mcpid_pkg::PH_KP;
         mcpid_pkg::PH_KP:  state_in = mcpid_pkg::PH_KIH;
         mcpid_pkg::PH_KIH: state_in = mcpid_pkg::PH_KIL;
         mcpid_pkg::PH_KIL: state_in = mcpid_pkg::PH_KD;
         mcpid_pkg::PH_KD:  state_in = mcpid_pkg::PH_FIN;
         mcpid_pkg::PH_FIN: begin
            // hold until the output register has room
            if (out_free) begin
               finish   = 1'b1;
               state_in = mcpid_pkg::PH_IDLE;
            end
         end
         default: state_in = mcpid_pkg::PH_IDLE;
      endcase
      rsp_valid_in = finish || (rsp_valid_ff && rsp_stall);
   end

   assign req_stall  = (state_ff != mcpid_pkg::PH_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign cmd.accept = accept;
   assign cmd.finish = finish;
   assign cmd.phase  = state_ff;

endmodule
`default_nettype wire

>>> hw/rtl/mcpid_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcpid_dp: datapath of the PID controller
// Channel table, defined bits, shared multiplier, accumulator and output.
// ----------------------------------------------------------------------------
module mcpid_dp (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     csr_we,
   input  wire                     csr_index,
   input  wire [30:0]              csr_wdata,
   input  mcpid_pkg::req_item_type req_item,
   output mcpid_pkg::rsp_item_type rsp_item,
   input  mcpid_pkg::dp_cmd_type   cmd,
   output mcpid_pkg::dp_sts_type   sts
);

   localparam int IW = mcpid_pkg::CH_IDX_W;

   logic [16:0]                 dt_ff;
   logic [30:0]                 inv_ff;
   mcpid_pkg::chan_rec_type     mem [mcpid_pkg::CHANNELS];
   mcpid_pkg::chan_rec_type     rdata_ff;
   mcpid_pkg::chan_rec_type     wdata;
   logic [mcpid_pkg::CHANNELS-1:0] defined_ff;
   logic [IW-1:0]               idx, idx_ff;
   logic                        in_range, is_def;
   mcpid_pkg::status_type       status, status_ff;
   logic                        func_ff;
   logic signed [31:0]          gp_ff, gi_ff, gd_ff;
   logic signed [32:0]          diff_in;
   logic signed [31:0]          e_ff, e_in;
   logic signed [47:0]          integ_ff;
   logic signed [31:0]          deriv_ff;
   logic signed [32:0]          opa, opb;
   logic                        issue;
   logic signed [65:0]          prod_ff;
   logic signed [49:0]          prod_sh;
   logic signed [65:0]          acc_ff;
   logic signed [65:0]          acc_fin;
   mcpid_pkg::rsp_item_type     rsp_ff;
   logic                        wr_en;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff  <= mcpid_pkg::TIME_STEP_RESET;
         inv_ff <= mcpid_pkg::INV_TIME_STEP_RESET;
      end else if (csr_we) begin
         if (csr_index == mcpid_pkg::CSR_TIME_STEP) begin
            dt_ff <= csr_wdata[16:0];
         end else begin
            inv_ff <= csr_wdata;
         end
      end
   end

   // classify the item waiting at the input
   always_comb begin
      idx      = IW'(req_item.channel);
      in_range = int'(req_item.channel) < mcpid_pkg::CHANNELS;
      is_def   = in_range && defined_ff[idx];
      if (req_item.func == mcpid_pkg::FUNC_LOAD) begin
         status = is_def || !in_range ? mcpid_pkg::STATUS_REDEF : mcpid_pkg::STATUS_OK;
      end else begin
         status = is_def ? mcpid_pkg::STATUS_OK : mcpid_pkg::STATUS_UNDEF;
      end
      sts.compute = (req_item.func == mcpid_pkg::FUNC_STEP) && is_def;
      diff_in = 33'(req_item.target) - 33'(req_item.measured);
      e_in    = mcpid_pkg::sat32(66'(diff_in));
   end

   // capture the item and read its table entry
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         idx_ff    <= idx;
         status_ff <= status;
         func_ff   <= req_item.func;
         gp_ff     <= req_item.gain_p;
         gi_ff     <= req_item.gain_i;
         gd_ff     <= req_item.gain_d;
         e_ff      <= e_in;
         rdata_ff  <= mem[idx];
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      issue = 1'b1;
      opa   = '0;
      opb   = '0;
      case (cmd.phase)
         mcpid_pkg::PH_EDT: begin
            opa = 33'(e_ff);
            opb = $signed({16'd0, dt_ff});
         end
         mcpid_pkg::PH_DIF: begin
            opa = 33'(e_ff) - 33'(rdata_ff.prev_err);
            opb = $signed({2'd0, inv_ff});
         end
         mcpid_pkg::PH_KP: begin
            opa = 33'(rdata_ff.gain_p);
            opb = 33'(e_ff);
         end
         mcpid_pkg::PH_KIH: begin
            opa = 33'(rdata_ff.gain_i);
            opb = 33'($signed(integ_ff[47:24]));
         end
         mcpid_pkg::PH_KIL: begin
            opa = 33'(rdata_ff.gain_i);
            opb = $signed({9'd0, integ_ff[23:0]});
         end
         mcpid_pkg::PH_KD: begin
            opa = 33'(rdata_ff.gain_d);
            opb = 33'(deriv_ff);
         end
         default: issue = 1'b0;
      endcase
   end

   // floor of the previous product over 2^16
   assign prod_sh = 50'(prod_ff >>> 16);

   // multiply, then fold the previous product in
   always_ff @(posedge clock) begin
      if (issue) begin
         prod_ff <= opa * opb;
      end
      case (cmd.phase)
         mcpid_pkg::PH_DIF: integ_ff <= mcpid_pkg::sat48(50'(rdata_ff.err_sum) + prod_sh);
         mcpid_pkg::PH_KP:  deriv_ff <= mcpid_pkg::sat32(66'(prod_sh));
         mcpid_pkg::PH_KIH: acc_ff   <= 66'(prod_sh);
         mcpid_pkg::PH_KIL: acc_ff   <= acc_ff + (prod_ff <<< 8);
         mcpid_pkg::PH_KD:  acc_ff   <= acc_ff + 66'(prod_sh);
         default: ;
      endcase
   end

   assign acc_fin = acc_ff + 66'(prod_sh);

   // write back the entry when an item completes with status OK
   always_comb begin
      wr_en = cmd.finish && (status_ff == mcpid_pkg::STATUS_OK);
      if (func_ff == mcpid_pkg::FUNC_LOAD) begin
         wdata.gain_p   = gp_ff;
         wdata.gain_i   = gi_ff;
         wdata.gain_d   = gd_ff;
         wdata.prev_err = '0;
         wdata.err_sum  = '0;
      end else begin
         wdata          = rdata_ff;
         wdata.prev_err = e_ff;
         wdata.err_sum  = integ_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_ff] <= wdata;
      end
   end

   // defined bits
   always_ff @(posedge clock) begin
      if (reset) begin
         defined_ff <= '0;
      end else if (wr_en && (func_ff == mcpid_pkg::FUNC_LOAD)) begin
         defined_ff[idx_ff] <= 1'b1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.status <= status_ff;
         if (status_ff == mcpid_pkg::STATUS_OK && func_ff == mcpid_pkg::FUNC_STEP) begin
            rsp_ff.drive <= mcpid_pkg::sat32(acc_fin);
         end else begin
            rsp_ff.drive <= '0;
         end
      end
   end

   assign rsp_item = rsp_ff;

endmodule
`default_nettype wire

>>> hw/rtl/mcpid_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcpid_checker: port-level checks for the PID controller
// Watches the handshakes and result codes at the top level.
// ----------------------------------------------------------------------------
module mcpid_checker (
   input wire                     clock,
   input wire                     reset,
   input wire                     req_valid,
   input wire                     req_stall,
   input wire                     rsp_valid,
   input wire                     rsp_stall,
   input mcpid_pkg::rsp_item_type rsp_item
);

   // a stalled result stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its value
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_item))
      else $error("result changed while stalled");

   // only defined status codes leave the block
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.status == mcpid_pkg::STATUS_OK ||
                     rsp_item.status == mcpid_pkg::STATUS_UNDEF ||
                     rsp_item.status == mcpid_pkg::STATUS_REDEF))
      else $error("unknown status code");

   // rejected items carry a zero drive
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status != mcpid_pkg::STATUS_OK |-> rsp_item.drive == 32'sd0)
      else $error("non-zero drive on a rejected item");

   // one item at a time: busy right after an acceptance
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item accepted back to back");

endmodule

bind multi_channel_pid_controller mcpid_checker u_mcpid_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);
`default_nettype wire
